FILE: hw/rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   localparam logic [OP_W-1:0] OP_READ = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [VALUE_W-1:0] READ_MISS = '1;

   typedef struct packed {
      logic               ins;
      logic               del;
      logic [POS_W-2:0]   pos;
      logic [VALUE_W-1:0] value;
   } ple_shift_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } ple_rsp_type;

endpackage

FILE: hw/rtl/ple_cell.sv
// One list slot: holds an entry and takes its neighbor's on insert or delete.
module ple_cell #(
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  ple_pkg::ple_shift_type        shift,
   input  logic [ple_pkg::VALUE_W-1:0]   left_entry,
   input  logic [ple_pkg::VALUE_W-1:0]   right_entry,
   output logic [ple_pkg::VALUE_W-1:0]   entry
);
   import ple_pkg::*;

   localparam logic [POS_W-2:0] MY_POS = (POS_W-1)'(IDX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift.ins) begin
         if (MY_POS > shift.pos) begin
            entry_in = left_entry;
         end else if (MY_POS == shift.pos) begin
            entry_in = shift.value;
         end
      end else if (shift.del) begin
         if (MY_POS >= shift.pos) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: hw/rtl/ple_out_queue.sv
// Two-slot response queue between the list and the response channel.
module ple_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ple_pkg::ple_rsp_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ple_pkg::ple_rsp_type rsp_data
);
   import ple_pkg::*;

   logic [1:0]  fill_ff, fill_in;
   ple_rsp_type slot0_ff, slot0_in;
   ple_rsp_type slot1_ff, slot1_in;
   logic        pop;

   assign full      = (fill_ff == 2'd2);
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      fill_in  = fill_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (fill_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            fill_in = fill_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            fill_in  = fill_ff - 2'd1;
         end
         2'b11: begin
            if (fill_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: decode, cell row and response queue.
//
// Usage:
//   The request channel (req_valid, req_stall) carries an operation, a
//   position and a value: read, insert at head, append at tail, insert
//   before a position, or delete at a position. The list lives in a row of
//   CAPACITY cells; on insert every cell above the position takes its lower
//   neighbor's entry, on delete every cell from the position up takes its
//   upper neighbor's, all in the same cycle.
//   Each request yields one response (rsp_valid, rsp_stall) with the read
//   value, a status (done, out of range, full) and the new length.
//   The response is registered in the response queue and leaves behind
//   any older ones. Throughput is one request per cycle while req_stall is low.
//   Responses wait in a two-slot queue; while the receiver stalls, one more
//   request is taken, then req_stall rises until a slot drains.
//   Reset empties the list and the queue; stored entries keep stale data
//   that is never read.
module positional_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ple_pkg::OP_W-1:0]       req_operation,
   input  logic signed [ple_pkg::POS_W-1:0]   req_position,
   input  logic signed [ple_pkg::VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [ple_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [ple_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ple_pkg::LEN_W-1:0]      rsp_length
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [CW-1:0]      count_ff, count_in;
   logic [VALUE_W-1:0] entry [CAPACITY];
   ple_shift_type      shift;
   ple_rsp_type        rsp_new, rsp_out;
   logic               push;
   logic               neg;
   logic [POS_W-1:0]   pos_u, cnt_ext;
   logic               list_full;

   assign push      = req_valid && !req_stall;
   assign neg       = req_position[POS_W-1];
   assign pos_u     = req_position;
   assign cnt_ext   = POS_W'(count_ff);
   assign list_full = (count_ff == FULL_COUNT);

   always_comb begin
      shift            = '0;
      shift.value      = req_value;
      rsp_new.read_value = '0;
      rsp_new.status     = ST_DONE;
      count_in         = count_ff;
      unique case (req_operation)
         OP_READ: begin
            if (neg || pos_u >= cnt_ext) begin
               rsp_new.read_value = READ_MISS;
               rsp_new.status     = ST_RANGE;
            end else begin
               rsp_new.read_value = entry[pos_u[IW-1:0]];
            end
         end
         OP_HEAD, OP_TAIL: begin
            if (list_full) begin
               rsp_new.status = ST_FULL;
            end else begin
               shift.ins = 1'b1;
               shift.pos = (req_operation == OP_TAIL) ? (POS_W-1)'(count_ff) : '0;
               count_in  = count_ff + CW'(1);
            end
         end
         OP_AT: begin
            if (!neg && pos_u > cnt_ext) begin
               rsp_new.status = ST_RANGE;
            end else if (list_full) begin
               rsp_new.status = ST_FULL;
            end else begin
               shift.ins = 1'b1;
               shift.pos = neg ? '0 : pos_u[POS_W-2:0];
               count_in  = count_ff + CW'(1);
            end
         end
         OP_DEL: begin
            if (neg || pos_u >= cnt_ext) begin
               rsp_new.status = ST_RANGE;
            end else begin
               shift.del = 1'b1;
               shift.pos = pos_u[POS_W-2:0];
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!push) begin
         shift.ins = 1'b0;
         shift.del = 1'b0;
         count_in  = count_ff;
      end
      rsp_new.length = LEN_W'(count_in);
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_entry, right_entry;
      if (g == 0) begin : g_first
         assign left_entry = req_value;
      end else begin : g_mid_l
         assign left_entry = entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = req_value;
      end else begin : g_mid_r
         assign right_entry = entry[g+1];
      end
      ple_cell #(
         .IDX (g)
      ) u_cell (
         .clock       (clock),
         .shift       (shift),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   ple_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rsp_new),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_out)
   );

   assign rsp_read_value = rsp_out.read_value;
   assign rsp_status     = rsp_out.status;
   assign rsp_length     = rsp_out.length;

endmodule

FILE: hw/rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
module ple_checker #(
   parameter int CAPACITY = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [ple_pkg::VALUE_W-1:0]     rsp_read_value,
   input logic [ple_pkg::STATUS_W-1:0]    rsp_status,
   input logic [ple_pkg::LEN_W-1:0]       rsp_length
);
   import ple_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled response changed");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= MAX_LEN)
      else $error("length above capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == MAX_LEN
         && rsp_read_value == '0)
      else $error("full status on a list that is not full");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind positional_list_engine ple_checker #(
   .CAPACITY (CAPACITY)
) u_ple_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status),
   .rsp_length     (rsp_length)
);

FILE: verif/tb.sv
// Testbench for the positional list engine: directed table, then random list traffic.
`timescale 1ns / 1ps

module tb;
   import ple_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_REQS  = 1500;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [POS_W-1:0]   pos;
      logic signed [VALUE_W-1:0] val;
      int                        reps;
      bit                        typed;
      ple_rsp_type               want;
   } dir_row_type;

   localparam int DIR_ROWS = 22;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OP_W-1:0]             req_operation = OP_READ;
   logic signed [POS_W-1:0]     req_position = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]   rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [LEN_W-1:0]            rsp_length;

   logic signed [VALUE_W-1:0]   list_mem [LIST_DEPTH];
   int                          list_len;
   ple_rsp_type                 pending_rsp [$];

   int                          send_idle_pct = 35;
   int                          recv_idle_pct = 62;
   bit                          hold_request = 1'b0;
   bit                          hold_done = 1'b0;
   int                          hold_left = 0;
   int                          error_count = 0;
   int                          cycle_count = 0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{OP_READ, -8'sd1,   32'h0,        1, 1'b1, '{READ_MISS, ST_RANGE, 7'd0}},
      '{OP_DEL,  8'sd0,    32'h0,        1, 1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_AT,   8'sd1,    32'h0,        1, 1'b1, '{32'h0, ST_RANGE, 7'd0}},
      '{OP_AT,   -8'sd128, 32'h7fffffff, 1, 1'b1, '{32'h0, ST_DONE, 7'd1}},
      '{OP_TAIL, 8'sd0,    32'h80000000, 1, 1'b1, '{32'h0, ST_DONE, 7'd2}},
      '{OP_HEAD, 8'sd127,  32'hffffffff, 1, 1'b1, '{32'h0, ST_DONE, 7'd3}},
      '{OP_READ, 8'sd2,    32'h0,        1, 1'b0, '{32'h0, ST_DONE, 7'd0}},
      '{OP_READ, 8'sd127,  32'h0,        1, 1'b1, '{READ_MISS, ST_RANGE, 7'd3}},
      '{OP_READ, -8'sd128, 32'h0,        1, 1'b1, '{READ_MISS, ST_RANGE, 7'd3}},
      '{OP_DEL,  -8'sd128, 32'h0,        1, 1'b1, '{32'h0, ST_RANGE, 7'd3}},
      '{OP_DEL,  8'sd3,    32'h0,        1, 1'b1, '{32'h0, ST_RANGE, 7'd3}},
      '{OP_AT,   8'sd3,    32'h55555555, 1, 1'b0, '{32'h0, ST_DONE, 7'd0}},
      '{OP_DEL,  8'sd1,    32'h0,        1, 1'b0, '{32'h0, ST_DONE, 7'd0}},
      '{3'd5,    -8'sd1,   32'hffffffff, 1, 1'b1, '{32'h0, ST_DONE, 7'd3}},
      '{3'd7,    8'sd0,    32'h12345678, 1, 1'b1, '{32'h0, ST_DONE, 7'd3}},
      '{OP_TAIL, 8'sd0,    32'h00001000, 13, 1'b0, '{32'h0, ST_DONE, 7'd0}},
      '{OP_TAIL, 8'sd0,    32'h0,        1, 1'b1, '{32'h0, ST_FULL, 7'(LIST_DEPTH)}},
      '{OP_HEAD, 8'sd0,    32'h0,        1, 1'b1, '{32'h0, ST_FULL, 7'(LIST_DEPTH)}},
      '{OP_AT,   8'sd16,   32'h0,        1, 1'b1, '{32'h0, ST_FULL, 7'(LIST_DEPTH)}},
      '{OP_AT,   8'sd17,   32'h0,        1, 1'b1, '{32'h0, ST_RANGE, 7'(LIST_DEPTH)}},
      '{OP_DEL,  8'sd15,   32'h0,        1, 1'b0, '{32'h0, ST_DONE, 7'd0}},
      '{OP_DEL,  8'sd0,    32'h0,        1, 1'b0, '{32'h0, ST_DONE, 7'd0}}
   };

   positional_list_engine #(
      .CAPACITY(LIST_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [STATUS_W-1:0] place_entry(input int slot,
                                                       input logic signed [VALUE_W-1:0] val);
      int i;
      if (list_len >= LIST_DEPTH) begin
         return ST_FULL;
      end
      for (i = list_len; i > slot; i--) begin
         list_mem[i] = list_mem[i-1];
      end
      list_mem[slot] = val;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic ple_rsp_type apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic signed [VALUE_W-1:0] val);
      ple_rsp_type r;
      int          p;
      int          i;
      r.read_value = '0;
      r.status     = ST_DONE;
      p            = int'(pos);
      case (op)
         OP_READ: begin
            if (p < 0 || p >= list_len) begin
               r.read_value = READ_MISS;
               r.status     = ST_RANGE;
            end else begin
               r.read_value = list_mem[p];
            end
         end
         OP_HEAD: r.status = place_entry(0, val);
         OP_TAIL: r.status = place_entry(list_len, val);
         OP_AT: begin
            if (p < 0) begin
               p = 0;
            end
            if (p > list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.status = place_entry(p, val);
            end
         end
         OP_DEL: begin
            if (p < 0 || p >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (i = p; i + 1 < list_len; i++) begin
                  list_mem[i] = list_mem[i+1];
               end
               list_len--;
            end
         end
         default: ;
      endcase
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   task automatic send_list_req(input logic [OP_W-1:0] op,
                                input logic signed [POS_W-1:0] pos,
                                input logic signed [VALUE_W-1:0] val,
                                input bit typed,
                                input ple_rsp_type want);
      ple_rsp_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      got = apply_list_op(op, pos, val);
      if (typed) begin
         got = want;
      end
      pending_rsp.insert(pending_rsp.size(), got);
   endtask

   task automatic pick_random_req(input int idx,
                                  output logic [OP_W-1:0] op,
                                  output logic signed [POS_W-1:0] pos,
                                  output logic signed [VALUE_W-1:0] val);
      int sel;
      bit grow;
      grow = ((idx / 120) % 2) == 0;
      sel  = $urandom_range(0, 99);
      val  = $urandom;
      pos  = POS_W'($urandom);
      if (sel < 3) begin
         op = OP_W'($urandom_range(5, 7));
      end else if (sel < 8) begin
         op = OP_W'($urandom_range(0, 4));
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            op = OP_READ;
         end else if (sel < (grow ? 35 : 28)) begin
            op = OP_HEAD;
         end else if (sel < (grow ? 55 : 36)) begin
            op = OP_TAIL;
         end else if (sel < (grow ? 80 : 50)) begin
            op = OP_AT;
         end else begin
            op = OP_DEL;
         end
         if (op == OP_AT) begin
            pos = POS_W'($urandom_range(0, list_len + 1));
         end else if (op != OP_HEAD && op != OP_TAIL) begin
            pos = POS_W'($urandom_range(0, list_len));
         end
      end
   endtask

   // response receiver: random stall plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      ple_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: read_value %0d status %0d length %0d",
                   rsp_read_value, rsp_status, rsp_length);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d",
                      $signed(want.read_value), rsp_read_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_length);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [OP_W-1:0]           op;
      logic signed [POS_W-1:0]   pos;
      logic signed [VALUE_W-1:0] val;
      ple_rsp_type               no_want;
      int                        r;
      int                        k;
      list_len = 0;
      no_want  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIR_ROWS; r++) begin
         for (k = 0; k < dir_rows[r].reps; k++) begin
            send_list_req(dir_rows[r].op, dir_rows[r].pos, dir_rows[r].val + k,
                          dir_rows[r].typed, dir_rows[r].want);
         end
      end

      for (r = 0; r < RANDOM_REQS; r++) begin
         if (r == RANDOM_REQS / 3) begin
            send_idle_pct = 62;
            recv_idle_pct = 35;
         end
         if (r == 2 * RANDOM_REQS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end
         pick_random_req(r, op, pos, val);
         send_list_req(op, pos, val, 1'b0, no_want);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_out_queue.sv
hw/rtl/positional_list_engine.sv
hw/rtl/ple_checker.sv
verif/tb.sv
